FILE: sv/assert_macros.svh
// Assertion macros shared by the pair contingency counter RTL.
// Included by the modules that carry concurrent assertions; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define PCC_ASSERT_IMPL(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition that must never be true at a clock edge outside reset.
`define PCC_ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

FILE: sv/pcc_pkg.sv
// Package for the pair contingency counter: field widths, codes, defaults and types.
// Used by the interfaces and every module of the block but pcc_ram; depends on nothing.
package pcc_pkg;

   // Default sizes of the counter store.
   localparam int MAX_DRUGS_DEF  = 8;
   localparam int MAX_EVENTS_DEF = 16;
   localparam int COUNT_BITS_DEF = 16;

   // Fixed widths of the transaction fields.
   localparam int OP_W         = 2;
   localparam int DRUG_BITS_W  = 8;
   localparam int EVENT_BITS_W = 16;
   localparam int DRUG_IDX_W   = 3;
   localparam int EVENT_IDX_W  = 4;
   localparam int DRUG_NUM_W   = 4;
   localparam int EVENT_NUM_W  = 5;

   // Configuration registers.
   localparam int DRUGS_REG_W  = 4;
   localparam int EVENTS_REG_W = 5;
   localparam int CSR_DATA_W   = 32;
   localparam int CSR_AW       = 3;
   localparam int CSR_IDX_W    = 1;
   localparam logic [CSR_IDX_W-1:0] REG_DRUGS  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_EVENTS = 1'b1;
   localparam logic [DRUGS_REG_W-1:0]  DRUGS_RESET  = 4'd8;
   localparam logic [EVENTS_REG_W-1:0] EVENTS_RESET = 5'd16;

   // Operation codes.
   localparam logic [OP_W-1:0] OP_ADD   = 2'd0;
   localparam logic [OP_W-1:0] OP_READ  = 2'd1;
   localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

   // Counter positions inside one pair's memory row.
   localparam int CELLS  = 4;
   localparam int CELL_W = 2;
   localparam logic [CELL_W-1:0] CELL_BOTH       = 2'd0;
   localparam logic [CELL_W-1:0] CELL_EVENT_ONLY = 2'd1;
   localparam logic [CELL_W-1:0] CELL_DRUG_ONLY  = 2'd2;
   localparam logic [CELL_W-1:0] CELL_NEITHER    = 2'd3;

   // Sequencer states.
   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ADD,
      ST_READ
   } state_type;

   // Memory access issued by the sequencer in one cycle.
   typedef struct packed {
      logic              rd;
      logic              rmw;
      logic              clr;
      logic [CELL_W-1:0] slot;
   } pcc_issue_type;

   // Result control from the sequencer to the output register.
   typedef struct packed {
      logic                   load;
      logic                   pair_ok;
      logic [DRUG_NUM_W-1:0]  drug_num;
      logic [EVENT_NUM_W-1:0] ev_num;
   } pcc_rsp_ctl_type;

endpackage

FILE: sv/pcc_req_if.sv
// Request channel of the pair contingency counter: valid, ready and one input item.
// Depends on pcc_pkg for the field widths.
interface pcc_req_if import pcc_pkg::*; ;

   logic                    valid;
   logic                    ready;
   logic [OP_W-1:0]         op;
   logic [DRUG_BITS_W-1:0]  drug_bits;
   logic [EVENT_BITS_W-1:0] event_bits;
   logic [DRUG_IDX_W-1:0]   drug_index;
   logic [EVENT_IDX_W-1:0]  event_index;

   modport source (
      output valid, op, drug_bits, event_bits, drug_index, event_index,
      input  ready
   );

   modport sink (
      input  valid, op, drug_bits, event_bits, drug_index, event_index,
      output ready
   );

endinterface

FILE: sv/pcc_rsp_if.sv
// Result channel of the pair contingency counter: valid, ready and one pair table.
// Depends on pcc_pkg for the field widths and the default counter width.
interface pcc_rsp_if import pcc_pkg::*; #(
   parameter int COUNT_BITS = COUNT_BITS_DEF
);

   logic                   valid;
   logic                   ready;
   logic                   index_valid;
   logic [DRUG_NUM_W-1:0]  drug_number;
   logic [EVENT_NUM_W-1:0] event_number;
   logic [COUNT_BITS-1:0]  count_both;
   logic [COUNT_BITS-1:0]  count_event_only;
   logic [COUNT_BITS-1:0]  count_drug_only;
   logic [COUNT_BITS-1:0]  count_neither;

   modport source (
      output valid, index_valid, drug_number, event_number,
             count_both, count_event_only, count_drug_only, count_neither,
      input  ready
   );

   modport sink (
      input  valid, index_valid, drug_number, event_number,
             count_both, count_event_only, count_drug_only, count_neither,
      output ready
   );

endinterface

FILE: sv/pcc_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Used for the counter store; no dependencies.
module pcc_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 128,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read port; the data holds until the next read.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: sv/pcc_csr.sv
// Configuration registers of the pair contingency counter behind an APB-style port.
// Depends on pcc_pkg for register indexes, widths and reset values.
module pcc_csr import pcc_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    psel,
   input  logic                    penable,
   input  logic                    pwrite,
   input  logic [CSR_AW-1:0]       paddr,
   input  logic [CSR_DATA_W-1:0]   pwdata,
   output logic [CSR_DATA_W-1:0]   prdata,
   output logic                    pready,
   output logic [DRUGS_REG_W-1:0]  drugs_in_use,
   output logic [EVENTS_REG_W-1:0] events_in_use
);

   logic [DRUGS_REG_W-1:0]  drugs_ff;
   logic [EVENTS_REG_W-1:0] events_ff;
   logic [CSR_IDX_W-1:0]    reg_idx;
   logic                    wr_stb;

   // Registers sit at word addresses; the index is the word number.
   assign reg_idx = paddr[CSR_AW-1:2];
   assign wr_stb  = psel && penable && pwrite;
   assign pready  = 1'b1;

   // Register writes complete in the access phase.
   always_ff @(posedge clock) begin
      if (reset) begin
         drugs_ff  <= DRUGS_RESET;
         events_ff <= EVENTS_RESET;
      end else if (wr_stb) begin
         unique case (reg_idx)
            REG_DRUGS:  drugs_ff  <= pwdata[DRUGS_REG_W-1:0];
            REG_EVENTS: events_ff <= pwdata[EVENTS_REG_W-1:0];
            default: ;
         endcase
      end
   end

   // Read-back mux.
   always_comb begin
      unique case (reg_idx)
         REG_DRUGS:  prdata = CSR_DATA_W'(drugs_ff);
         REG_EVENTS: prdata = CSR_DATA_W'(events_ff);
         default:    prdata = '0;
      endcase
   end

   assign drugs_in_use  = drugs_ff;
   assign events_in_use = events_ff;

endmodule

FILE: sv/pcc_ctrl.sv
// Sequencer of the pair contingency counter: takes transactions, walks the pairs of a
// report, issues memory reads and the clearing sweep. Depends on pcc_pkg and pcc_req_if.
module pcc_ctrl import pcc_pkg::*; #(
   parameter int MAX_DRUGS  = MAX_DRUGS_DEF,
   parameter int MAX_EVENTS = MAX_EVENTS_DEF,
   parameter int DEPTH      = MAX_DRUGS_DEF * MAX_EVENTS_DEF,
   parameter int AW         = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                    clock,
   input  logic                    reset,
   pcc_req_if.sink                 req_bus,
   input  logic [DRUGS_REG_W-1:0]  drugs_in_use,
   input  logic [EVENTS_REG_W-1:0] events_in_use,
   input  logic                    wb_busy,
   input  logic                    rsp_free,
   output pcc_issue_type           issue,
   output logic [AW-1:0]           mem_addr,
   output pcc_rsp_ctl_type         rsp_ctl
);

   localparam int DRUG_LIM  = 2 ** DRUGS_REG_W - 1;
   localparam int EVENT_LIM = 2 ** EVENTS_REG_W - 1;
   localparam logic [DRUGS_REG_W-1:0] ND_CAP =
      DRUGS_REG_W'((MAX_DRUGS < DRUG_LIM) ? MAX_DRUGS : DRUG_LIM);
   localparam logic [EVENTS_REG_W-1:0] NE_CAP =
      EVENTS_REG_W'((MAX_EVENTS < EVENT_LIM) ? MAX_EVENTS : EVENT_LIM);
   localparam int DBIT_IW = $clog2(DRUG_BITS_W);
   localparam int EBIT_IW = $clog2(EVENT_BITS_W);

   state_type               state_ff, state_in;
   logic [DRUGS_REG_W-1:0]  di_ff, di_in;
   logic [EVENTS_REG_W-1:0] ej_ff, ej_in;
   logic [DRUG_BITS_W-1:0]  dbits_ff, dbits_in;
   logic [EVENT_BITS_W-1:0] ebits_ff, ebits_in;
   logic [AW-1:0]           clr_ff, clr_in;
   logic                    rq_ok_ff, rq_ok_in;
   logic [DRUG_NUM_W-1:0]   rq_dnum_ff, rq_dnum_in;
   logic [EVENT_NUM_W-1:0]  rq_evnum_ff, rq_evnum_in;

   logic [DRUGS_REG_W-1:0]  nd;
   logic [EVENTS_REG_W-1:0] ne;
   logic                    pair_go;
   logic                    d_last;
   logic                    e_last;
   logic                    drug_here;
   logic                    event_here;
   logic                    read_ok;
   logic                    take;
   logic [AW-1:0]           add_addr;
   logic [AW-1:0]           read_addr;
   logic [CELL_W-1:0]       hit_slot;

   // Sizes in use, limited to the store.
   assign nd      = (drugs_in_use > ND_CAP) ? ND_CAP : drugs_in_use;
   assign ne      = (events_in_use > NE_CAP) ? NE_CAP : events_in_use;
   assign pair_go = (nd != '0) && (ne != '0);

   // Pair walk position and the cell hit by the current report.
   assign d_last     = (di_ff == nd - DRUGS_REG_W'(1));
   assign e_last     = (ej_ff == ne - EVENTS_REG_W'(1));
   assign drug_here  = (32'(di_ff) < DRUG_BITS_W) && dbits_ff[di_ff[DBIT_IW-1:0]];
   assign event_here = (32'(ej_ff) < EVENT_BITS_W) && ebits_ff[ej_ff[EBIT_IW-1:0]];
   assign hit_slot   = drug_here ? (event_here ? CELL_BOTH : CELL_DRUG_ONLY)
                                 : (event_here ? CELL_EVENT_ONLY : CELL_NEITHER);
   assign add_addr   = AW'(32'(di_ff) * MAX_EVENTS + 32'(ej_ff));

   // Read transaction decode.
   assign read_ok   = (DRUGS_REG_W'(req_bus.drug_index) < nd) &&
                      (EVENTS_REG_W'(req_bus.event_index) < ne);
   assign read_addr = AW'(32'(req_bus.drug_index) * MAX_EVENTS + 32'(req_bus.event_index));
   assign take      = req_bus.valid && req_bus.ready;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == AW'(DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (take) begin
               unique case (req_bus.op)
                  OP_ADD:   state_in = pair_go ? ST_ADD : ST_IDLE;
                  OP_READ:  state_in = ST_READ;
                  OP_CLEAR: state_in = ST_CLEAR;
                  default:  state_in = ST_IDLE;
               endcase
            end
         end
         ST_ADD: begin
            if (d_last && e_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_READ: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs: handshake, memory access and result load.
   always_comb begin
      req_bus.ready = 1'b0;
      issue         = '0;
      mem_addr      = add_addr;
      rsp_ctl.load  = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            issue.clr = 1'b1;
            mem_addr  = clr_ff;
         end
         ST_IDLE: begin
            req_bus.ready = !wb_busy;
            mem_addr      = read_addr;
            issue.rd      = take && (req_bus.op == OP_READ) && read_ok;
         end
         ST_ADD: begin
            issue.rd   = 1'b1;
            issue.rmw  = 1'b1;
            issue.slot = hit_slot;
         end
         ST_READ: begin
            rsp_ctl.load = rsp_free;
         end
         default: ;
      endcase
      rsp_ctl.pair_ok  = rq_ok_ff;
      rsp_ctl.drug_num = rq_dnum_ff;
      rsp_ctl.ev_num   = rq_evnum_ff;
   end

   // Walk counters, sweep address and captured transaction fields.
   always_comb begin
      di_in       = di_ff;
      ej_in       = ej_ff;
      dbits_in    = dbits_ff;
      ebits_in    = ebits_ff;
      clr_in      = clr_ff;
      rq_ok_in    = rq_ok_ff;
      rq_dnum_in  = rq_dnum_ff;
      rq_evnum_in = rq_evnum_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + AW'(1);
         end
         ST_IDLE: begin
            if (take) begin
               di_in       = '0;
               ej_in       = '0;
               clr_in      = '0;
               dbits_in    = req_bus.drug_bits;
               ebits_in    = req_bus.event_bits;
               rq_ok_in    = read_ok;
               rq_dnum_in  = read_ok ? DRUG_NUM_W'(req_bus.drug_index) + DRUG_NUM_W'(1)
                                     : '0;
               rq_evnum_in = read_ok ? EVENT_NUM_W'(req_bus.event_index) + EVENT_NUM_W'(1)
                                     : '0;
            end
         end
         ST_ADD: begin
            if (e_last) begin
               ej_in = '0;
               di_in = di_ff + DRUGS_REG_W'(1);
            end else begin
               ej_in = ej_ff + EVENTS_REG_W'(1);
            end
         end
         default: ;
      endcase
   end

   // Control registers; reset starts the clearing sweep at row zero.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
      end
   end

   // Data registers.
   always_ff @(posedge clock) begin
      di_ff       <= di_in;
      ej_ff       <= ej_in;
      dbits_ff    <= dbits_in;
      ebits_ff    <= ebits_in;
      rq_ok_ff    <= rq_ok_in;
      rq_dnum_ff  <= rq_dnum_in;
      rq_evnum_ff <= rq_evnum_in;
   end

endmodule

FILE: sv/pcc_update.sv
// Write-back stage of the pair contingency counter: saturating increment of one counter
// in the row just read, and the zero writes of the clearing sweep. Depends on pcc_pkg.
`include "assert_macros.svh"

module pcc_update import pcc_pkg::*; #(
   parameter int COUNT_BITS = COUNT_BITS_DEF,
   parameter int AW         = 7,
   localparam int ROW_W     = CELLS * COUNT_BITS
) (
   input  logic             clock,
   input  logic             reset,
   input  pcc_issue_type    issue,
   input  logic [AW-1:0]    mem_addr,
   input  logic [ROW_W-1:0] rd_data,
   output logic             wr_en,
   output logic [AW-1:0]    wr_addr,
   output logic [ROW_W-1:0] wr_data,
   output logic             wb_busy
);

   logic                  wb_valid_ff;
   logic [AW-1:0]         wb_addr_ff;
   logic [CELL_W-1:0]     wb_cell_ff;
   logic [COUNT_BITS-1:0] sel_cnt;
   logic [COUNT_BITS-1:0] inc_cnt;
   logic [ROW_W-1:0]      new_row;

   // The write-back comes in the cycle after the read.
   always_ff @(posedge clock) begin
      if (reset) begin
         wb_valid_ff <= 1'b0;
      end else begin
         wb_valid_ff <= issue.rmw;
      end
   end

   always_ff @(posedge clock) begin
      wb_addr_ff <= mem_addr;
      wb_cell_ff <= issue.slot;
   end

   // Saturating increment of the selected counter.
   assign sel_cnt = rd_data[wb_cell_ff * COUNT_BITS +: COUNT_BITS];
   assign inc_cnt = (&sel_cnt) ? sel_cnt : sel_cnt + COUNT_BITS'(1);

   always_comb begin
      for (int k = 0; k < CELLS; k++) begin
         new_row[k * COUNT_BITS +: COUNT_BITS] =
            (CELL_W'(k) == wb_cell_ff) ? inc_cnt : rd_data[k * COUNT_BITS +: COUNT_BITS];
      end
   end

   // Write port: pending update, else a sweep row of zeros.
   assign wr_en   = wb_valid_ff || issue.clr;
   assign wr_addr = wb_valid_ff ? wb_addr_ff : mem_addr;
   assign wr_data = wb_valid_ff ? new_row : '0;
   assign wb_busy = wb_valid_ff;

   `PCC_ASSERT_NEVER(a_sweep_vs_update, clock, reset, issue.clr && wb_valid_ff, "sweep write collides with a counter update")

endmodule

FILE: sv/pair_contingency_counter_core.sv
// Add transaction: accepted, then one counter read-modify-write per pair in use, one pair a
// cycle on the single memory read port, then a final write-back during which none is accepted.
// Read transaction: none other is accepted until its result is loaded into the free output register.
// Clear transaction and reset: a sweep zeroes all MAX_DRUGS*MAX_EVENTS pair rows (128 by
// default), one row a cycle, and accepts no transaction meanwhile; CSR writes still work.
`include "assert_macros.svh"

module pair_contingency_counter_core import pcc_pkg::*; #(
   parameter int MAX_DRUGS  = MAX_DRUGS_DEF,
   parameter int MAX_EVENTS = MAX_EVENTS_DEF,
   parameter int COUNT_BITS = COUNT_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   pcc_req_if.sink               req_bus,
   pcc_rsp_if.source             rsp_bus,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_AW-1:0]     paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   localparam int DEPTH = MAX_DRUGS * MAX_EVENTS;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int ROW_W = CELLS * COUNT_BITS;

   logic [DRUGS_REG_W-1:0]  drugs_in_use;
   logic [EVENTS_REG_W-1:0] events_in_use;
   pcc_issue_type           issue;
   pcc_rsp_ctl_type         rsp_ctl;
   logic [AW-1:0]           mem_addr;
   logic                    wr_en;
   logic [AW-1:0]           wr_addr;
   logic [ROW_W-1:0]        wr_data;
   logic [ROW_W-1:0]        rd_data;
   logic                    wb_busy;
   logic                    rsp_free;

   logic                   rsp_valid_ff;
   logic                   rsp_ok_ff;
   logic [DRUG_NUM_W-1:0]  rsp_dnum_ff;
   logic [EVENT_NUM_W-1:0] rsp_evnum_ff;
   logic [ROW_W-1:0]       rsp_row_ff;

   pcc_csr u_csr (
      .clock         (clock),
      .reset         (reset),
      .psel          (psel),
      .penable       (penable),
      .pwrite        (pwrite),
      .paddr         (paddr),
      .pwdata        (pwdata),
      .prdata        (prdata),
      .pready        (pready),
      .drugs_in_use  (drugs_in_use),
      .events_in_use (events_in_use)
   );

   pcc_ctrl #(
      .MAX_DRUGS  (MAX_DRUGS),
      .MAX_EVENTS (MAX_EVENTS),
      .DEPTH      (DEPTH),
      .AW         (AW)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_bus       (req_bus),
      .drugs_in_use  (drugs_in_use),
      .events_in_use (events_in_use),
      .wb_busy       (wb_busy),
      .rsp_free      (rsp_free),
      .issue         (issue),
      .mem_addr      (mem_addr),
      .rsp_ctl       (rsp_ctl)
   );

   pcc_ram #(
      .WIDTH (ROW_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (issue.rd),
      .rd_addr (mem_addr),
      .rd_data (rd_data)
   );

   pcc_update #(
      .COUNT_BITS (COUNT_BITS),
      .AW         (AW)
   ) u_update (
      .clock    (clock),
      .reset    (reset),
      .issue    (issue),
      .mem_addr (mem_addr),
      .rd_data  (rd_data),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_data  (wr_data),
      .wb_busy  (wb_busy)
   );

   // The output register can take a new result when empty or being drained.
   assign rsp_free = !rsp_valid_ff || rsp_bus.ready;

   // Output register valid flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_ctl.load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Output register payload; an invalid pair reports all zeros.
   always_ff @(posedge clock) begin
      if (rsp_ctl.load) begin
         rsp_ok_ff    <= rsp_ctl.pair_ok;
         rsp_dnum_ff  <= rsp_ctl.drug_num;
         rsp_evnum_ff <= rsp_ctl.ev_num;
         rsp_row_ff   <= rsp_ctl.pair_ok ? rd_data : '0;
      end
   end

   assign rsp_bus.valid            = rsp_valid_ff;
   assign rsp_bus.index_valid      = rsp_ok_ff;
   assign rsp_bus.drug_number      = rsp_dnum_ff;
   assign rsp_bus.event_number     = rsp_evnum_ff;
   assign rsp_bus.count_both       =
      rsp_row_ff[int'(CELL_BOTH) * COUNT_BITS +: COUNT_BITS];
   assign rsp_bus.count_event_only =
      rsp_row_ff[int'(CELL_EVENT_ONLY) * COUNT_BITS +: COUNT_BITS];
   assign rsp_bus.count_drug_only  =
      rsp_row_ff[int'(CELL_DRUG_ONLY) * COUNT_BITS +: COUNT_BITS];
   assign rsp_bus.count_neither    =
      rsp_row_ff[int'(CELL_NEITHER) * COUNT_BITS +: COUNT_BITS];

   `PCC_ASSERT_IMPL(a_rsp_no_overwrite, clock, reset, rsp_ctl.load |-> !rsp_valid_ff || rsp_bus.ready, "result loaded over one not yet taken")
   `PCC_ASSERT_IMPL(a_rmw_no_overlap, clock, reset, issue.rd && wr_en |-> mem_addr != wr_addr, "read and write of the same pair row in one cycle")
   `PCC_ASSERT_IMPL(a_ready_after_wb, clock, reset, wb_busy |-> !req_bus.ready, "transaction taken while a counter update is pending")

endmodule
